// ===== rtl/fiwm_pkg.sv =====
// shared types and constants for the frame interval window median block
package fiwm_pkg;

   // register indexes on the csr port
   localparam logic CSR_START_TIME = 1'b0;
   localparam logic CSR_TICK_SCALE = 1'b1;

   // reset value of the scale register, 1.0 in q32.32
   localparam logic [63:0] TICK_SCALE_RESET = 64'h0000_0001_0000_0000;

   // width of the pair count on the result channel
   localparam int PAIRS_WIDTH = 7;

   // operation applied to every cell of the sorted chain in the same cycle
   typedef struct packed {
      logic remove;
      logic insert;
   } cell_op_type;

   // sequencer states of the top level
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_INSERT,
      ST_PICK,
      ST_SCALE,
      ST_SEND
   } state_type;

endpackage

// ===== rtl/frame_interval_window_median_unit.sv =====
// top level: pair history, sorted cell chain, median pick and scaling
// a beat is taken only in idle, then passes the remove, insert and pick steps of
//   the chain, then start, four partial products, saturation and done of the scaler
// a response still held in the output register stalls the next item at its send step
// reset: all pairs invalid, start_time 0, tick_scale 1.0, nothing in flight
module frame_interval_window_median_unit #(
   parameter int RING_DEPTH = 128,
   parameter int TIME_WIDTH = 48
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [TIME_WIDTH-1:0]                 req_now_time,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [TIME_WIDTH:0]            rsp_median_delta,
   output logic signed [63:0]                    rsp_median_scaled,
   output logic [fiwm_pkg::PAIRS_WIDTH-1:0]      rsp_valid_pairs,
   input  logic                                  csr_write,
   input  logic                                  csr_index,
   input  logic [63:0]                           csr_data
);
   import fiwm_pkg::*;

   localparam int DW    = TIME_WIDTH + 1;
   localparam int NCELL = RING_DEPTH - 1;
   localparam int CNTW  = $clog2(RING_DEPTH);
   localparam int CW    = $clog2(NCELL);

   // configuration registers
   logic [TIME_WIDTH-1:0] start_time_ff;
   logic [63:0]           tick_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff <= '0;
         tick_scale_ff <= TICK_SCALE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_START_TIME: start_time_ff <= csr_data[TIME_WIDTH-1:0];
            CSR_TICK_SCALE: tick_scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // new entry and the pair it forms with the previous newest entry
   logic [TIME_WIDTH-1:0] last_ff;
   logic [TIME_WIDTH-1:0] v_new;
   logic signed [DW-1:0]  d_new;
   logic                  p_new;

   assign v_new = req_now_time - start_time_ff;
   assign d_new = $signed({1'b0, v_new}) - $signed({1'b0, last_ff});
   assign p_new = (v_new != '0) && (last_ff != '0);

   // pair history shift line, the last tap is the pair that leaves
   logic signed [DW-1:0] line_ff [NCELL];
   logic [NCELL-1:0]     line_vld_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         line_ff[0] <= d_new;
         for (int i = 1; i < NCELL; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
      if (reset) begin
         line_vld_ff <= '0;
         last_ff     <= '0;
      end else if (accept) begin
         line_vld_ff <= {line_vld_ff[NCELL-2:0], p_new};
         last_ff     <= v_new;
      end
   end

   // keys for the chain update and the pair count
   logic signed [DW-1:0] rem_key_ff, ins_key_ff;
   logic                 rem_vld_ff, ins_vld_ff;
   logic [CNTW-1:0]      count_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         rem_key_ff <= line_ff[NCELL-1];
         ins_key_ff <= d_new;
      end
      if (reset) begin
         rem_vld_ff <= 1'b0;
         ins_vld_ff <= 1'b0;
         count_ff   <= '0;
      end else if (accept) begin
         rem_vld_ff <= line_vld_ff[NCELL-1];
         ins_vld_ff <= p_new;
         count_ff   <= count_ff + CNTW'(p_new) - CNTW'(line_vld_ff[NCELL-1]);
      end
   end

   // sorted cell chain
   cell_op_type          op;
   logic signed [DW-1:0] key;
   logic signed [DW-1:0] cell_val [NCELL];
   logic [NCELL-1:0]     cell_vld;
   logic [NCELL-1:0]     cell_hit;

   assign op.remove = (state_ff == ST_REMOVE) && rem_vld_ff;
   assign op.insert = (state_ff == ST_INSERT) && ins_vld_ff;
   assign key       = (state_ff == ST_REMOVE) ? rem_key_ff : ins_key_ff;

   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      logic signed [DW-1:0] pv, nv;
      logic                 ph, pvl, nvl;
      if (g == 0) begin : g_first
         assign pv  = '0;
         assign ph  = 1'b0;
         assign pvl = 1'b0;
      end else begin : g_mid
         assign pv  = cell_val[g-1];
         assign ph  = cell_hit[g-1];
         assign pvl = cell_vld[g-1];
      end
      if (g == NCELL - 1) begin : g_last
         assign nv  = '0;
         assign nvl = 1'b0;
      end else begin : g_up
         assign nv  = cell_val[g+1];
         assign nvl = cell_vld[g+1];
      end
      fiwm_sort_cell #(.DW(DW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .op       (op),
         .key      (key),
         .prev_val (pv),
         .prev_hit (ph),
         .prev_vld (pvl),
         .next_val (nv),
         .next_vld (nvl),
         .hit      (cell_hit[g]),
         .val      (cell_val[g]),
         .vld      (cell_vld[g])
      );
   end

   // upper median pick
   logic signed [DW-1:0] median_ff;
   logic [CW-1:0]        mid_idx;

   assign mid_idx = CW'(count_ff >> 1);

   always_ff @(posedge clock) begin
      if (state_ff == ST_PICK) begin
         median_ff <= (count_ff == '0) ? '0 : cell_val[mid_idx];
      end
   end

   // scaling unit, started in the first scale cycle
   logic               sc_start, sc_done;
   logic               sc_start_ff;
   logic signed [63:0] sc_result;
   logic [DW-1:0]      med_mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_start_ff <= 1'b0;
      end else begin
         sc_start_ff <= (state_ff == ST_PICK);
      end
   end

   assign med_mag  = median_ff[DW-1] ? DW'(-median_ff) : DW'(median_ff);
   assign sc_start = (state_ff == ST_SCALE) && sc_start_ff;

   fiwm_scale u_scale (
      .clock  (clock),
      .reset  (reset),
      .start  (sc_start),
      .neg    (median_ff[DW-1]),
      .mag    (64'(med_mag)),
      .scale  (tick_scale_ff),
      .done   (sc_done),
      .result (sc_result)
   );

   // response register
   logic rsp_valid_ff;
   logic load_rsp;

   assign load_rsp = (state_ff == ST_SEND) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_median_delta  <= median_ff;
         rsp_median_scaled <= sc_result;
         rsp_valid_pairs   <= PAIRS_WIDTH'(count_ff);
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_REMOVE;
         ST_REMOVE: state_in = ST_INSERT;
         ST_INSERT: state_in = ST_PICK;
         ST_PICK:   state_in = ST_SCALE;
         ST_SCALE:  if (sc_done) state_in = ST_SEND;
         ST_SEND:   if (load_rsp) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // pair count never exceeds the chain length
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(NCELL)) else $error("pair count overflow");
   // chain occupancy matches the pair count once updated
   a_chain_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK) |-> ($countones(cell_vld) == int'(count_ff)))
      else $error("cell chain occupancy mismatch");
   // the scaling unit finishes only while the sequencer waits for it
   a_done_state: assert property (@(posedge clock) disable iff (reset)
      sc_done |-> (state_ff == ST_SCALE)) else $error("stray scale done");

endmodule

// ===== rtl/fiwm_sort_cell.sv =====
// one cell of the sorted difference chain, empty cells act as plus infinity
module fiwm_sort_cell #(
   parameter int DW = 49
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fiwm_pkg::cell_op_type    op,
   input  logic signed [DW-1:0]     key,
   input  logic signed [DW-1:0]     prev_val,
   input  logic                     prev_hit,
   input  logic                     prev_vld,
   input  logic signed [DW-1:0]     next_val,
   input  logic                     next_vld,
   output logic                     hit,
   output logic signed [DW-1:0]     val,
   output logic                     vld
);
   import fiwm_pkg::*;

   logic signed [DW-1:0] val_ff, val_in;
   logic                 vld_ff, vld_in;

   // compare against the key, >= for removal and > for insertion
   assign hit = !vld_ff || (op.remove ? (val_ff >= key) : (val_ff > key));
   assign val = val_ff;
   assign vld = vld_ff;

   // removal pulls from the upper neighbor, insertion pushes from the lower
   always_comb begin
      val_in = val_ff;
      vld_in = vld_ff;
      if (op.remove && hit) begin
         val_in = next_val;
         vld_in = next_vld;
      end else if (op.insert && hit) begin
         if (prev_hit) begin
            val_in = prev_val;
            vld_in = prev_vld;
         end else begin
            val_in = key;
            vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

endmodule

// ===== rtl/fiwm_scale.sv =====
// signed median times unsigned q32.32 factor, four 32x32 partial products
module fiwm_scale (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               neg,
   input  logic [63:0]        mag,
   input  logic [63:0]        scale,
   output logic               done,
   output logic signed [63:0] result
);
   import fiwm_pkg::*;

   logic [127:0]       acc_ff, acc_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic signed [63:0] result_ff, result_in;
   logic               neg_ff;
   logic [63:0]        mag_ff;

   logic [31:0]  a_part, s_part;
   logic [63:0]  pp;
   logic [127:0] pp_sh;
   logic [63:0]  q;
   logic [64:0]  q_up;
   logic         over;

   // operand halves chosen by the step counter
   assign a_part = cnt_ff[1] ? mag_ff[63:32] : mag_ff[31:0];
   assign s_part = cnt_ff[0] ? scale[63:32] : scale[31:0];
   assign pp     = a_part * s_part;

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    pp_sh = {64'd0, pp};
         2'd3:    pp_sh = {pp, 64'd0};
         default: pp_sh = {32'd0, pp, 32'd0};
      endcase
   end

   // floor shift by 32 and saturation
   assign q    = acc_ff[95:32];
   assign over = acc_ff[127:96] != 32'd0;
   assign q_up = {1'b0, q} + {64'd0, (acc_ff[31:0] != 32'd0)};

   always_comb begin
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      if (start) begin
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff[2]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (!neg_ff) begin
               result_in = (over || q[63]) ? 64'sh7fff_ffff_ffff_ffff : $signed(q);
            end else if (over || q_up[64] || q_up[63]) begin
               result_in = 64'sh8000_0000_0000_0000;
            end else begin
               result_in = -$signed(q_up[63:0]);
            end
         end else begin
            acc_in = acc_ff + pp_sh;
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      cnt_ff    <= cnt_in;
      result_ff <= result_in;
      if (start) begin
         neg_ff <= neg;
         mag_ff <= mag;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

   // done is a single pulse
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("scale done held");
   // no new start while the unit works
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("scale restarted while busy");
   // counter stays within the four products and the final step
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff <= 3'd4)) else $error("scale step out of range");

endmodule
